@@ sv/sgt_pkg.sv @@
// Shared widths, codes and control types of the sequence gap tracker.
package sgt_pkg;

   localparam int unsigned GAP_SLOTS_DEFAULT = 16;

   localparam int unsigned PKT_LEN_W   = 12;
   localparam int unsigned SEQ_W       = 64;
   localparam int unsigned MSG_CNT_W   = 16;
   localparam int unsigned GAP_SIZE_W  = 16;
   localparam int unsigned VERDICT_W   = 3;
   localparam int unsigned OPEN_GAPS_W = 5;
   localparam int unsigned MISSING_W   = 20;
   localparam int unsigned COUNTER_W   = 32;

   localparam logic [PKT_LEN_W-1:0] MIN_HEADER_RESET = 12'd20;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_IN_ORDER  = 3'd0,
      VERDICT_GAP       = 3'd1,
      VERDICT_RECOVERED = 3'd2,
      VERDICT_DUPLICATE = 3'd3,
      VERDICT_SHORT     = 3'd4
   } verdict_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_JUDGE,
      ST_FIND,
      ST_DIFF,
      ST_CHECK,
      ST_STORE,
      ST_STORE_WR,
      ST_SUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_first;
      logic wr_size;
      logic set_valid;
      logic clr_valid;
   } tbl_cmd_type;

endpackage

@@ sv/sgt_req_if.sv @@
// Packet header channel of the sequence gap tracker.
interface sgt_req_if import sgt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PKT_LEN_W-1:0] packet_length;
   logic [SEQ_W-1:0]     sequence_req;
   logic [MSG_CNT_W-1:0] message_count;

   modport source (output valid, output packet_length, output sequence_req,
                   output message_count, input ready);
   modport sink   (input valid, input packet_length, input sequence_req,
                   input message_count, output ready);
endinterface

@@ sv/sgt_rsp_if.sv @@
// Result channel of the sequence gap tracker.
interface sgt_rsp_if import sgt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [VERDICT_W-1:0]   verdict;
   logic                   accepted;
   logic [SEQ_W-1:0]       expected_next;
   logic [OPEN_GAPS_W-1:0] open_gaps;
   logic [MISSING_W-1:0]   missing_total;
   logic [COUNTER_W-1:0]   gap_openings;
   logic [COUNTER_W-1:0]   duplicates;
   logic [COUNTER_W-1:0]   recovered_messages;
   logic [COUNTER_W-1:0]   packets_seen;
   logic                   table_overflow;

   modport source (output valid, output verdict, output accepted, output expected_next,
                   output open_gaps, output missing_total, output gap_openings,
                   output duplicates, output recovered_messages, output packets_seen,
                   output table_overflow, input ready);
   modport sink   (input valid, input verdict, input accepted, input expected_next,
                   input open_gaps, input missing_total, input gap_openings,
                   input duplicates, input recovered_messages, input packets_seen,
                   input table_overflow, output ready);
endinterface

@@ sv/sgt_gap_table.sv @@
// Gap table: valid flags in flip-flops, gap starts and sizes in memories.
module sgt_gap_table import sgt_pkg::*; #(
   parameter int unsigned GAP_SLOTS = GAP_SLOTS_DEFAULT,
   localparam int unsigned SLOT_W = (GAP_SLOTS > 1) ? $clog2(GAP_SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tbl_cmd_type           cmd,
   input  logic [SLOT_W-1:0]     rd_addr,
   input  logic [SLOT_W-1:0]     wr_addr,
   input  logic [SEQ_W-1:0]      wr_first,
   input  logic [GAP_SIZE_W-1:0] wr_size,
   output logic                  rd_valid,
   output logic [SEQ_W-1:0]      rd_first,
   output logic [GAP_SIZE_W-1:0] rd_size
);

   logic [GAP_SLOTS-1:0]  valid_ff;
   logic [GAP_SLOTS-1:0]  valid_in;
   logic [SEQ_W-1:0]      gap_first_mem [GAP_SLOTS];
   logic [GAP_SIZE_W-1:0] gap_size_mem  [GAP_SLOTS];
   logic                  rd_valid_ff;
   logic [SEQ_W-1:0]      rd_first_ff;
   logic [GAP_SIZE_W-1:0] rd_size_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.set_valid) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (cmd.clr_valid) begin
         valid_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_first) begin
         gap_first_mem[wr_addr] <= wr_first;
      end
      if (cmd.wr_size) begin
         gap_size_mem[wr_addr] <= wr_size;
      end
      if (cmd.rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
         rd_first_ff <= gap_first_mem[rd_addr];
         rd_size_ff  <= gap_size_mem[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_first = rd_first_ff;
   assign rd_size  = rd_size_ff;

endmodule

@@ sv/sequence_gap_tracker.sv @@
// Top level of the packet sequence gap tracker.
//
//   channel   dir  handshake         content
//   req_ch    in   valid/ready       packet_length, sequence_req, message_count
//   rsp_ch    out  valid/ready       verdict, tracker snapshot, table_overflow
//   csr_*     in   csr_wr_en         min_header_bytes
//
// One header at a time; each pass over the gap table reads every slot through
// the table's single read port. Short or in-order packet: summing pass only;
// new gap: store pass, then sum; split recovery: find, store per part, then sum.
// Synchronous reset clears the table flags, counters and expected sequence.
// A result waits in the output register; the next header is taken meanwhile
// and its result waits until the register is free.
module sequence_gap_tracker import sgt_pkg::*; #(
   parameter int unsigned GAP_SLOTS = GAP_SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [PKT_LEN_W-1:0] csr_wr_data,
   sgt_req_if.sink              req_ch,
   sgt_rsp_if.source            rsp_ch
);

   localparam int unsigned SLOT_W = (GAP_SLOTS > 1) ? $clog2(GAP_SLOTS) : 1;
   localparam int unsigned IDX_W  = $clog2(GAP_SLOTS + 1);
   localparam int unsigned SUM_W  = GAP_SIZE_W + IDX_W;
   localparam int unsigned NG_W   = (IDX_W > OPEN_GAPS_W) ? IDX_W : OPEN_GAPS_W;
   localparam int unsigned MS_W   = (SUM_W > MISSING_W) ? SUM_W : MISSING_W;

   state_type              state_ff, state_in;
   logic [PKT_LEN_W-1:0]   min_ff, min_in;
   logic [SEQ_W-1:0]       next_exp_ff, next_exp_in;
   logic [COUNTER_W-1:0]   gap_cnt_ff, gap_cnt_in;
   logic [COUNTER_W-1:0]   dup_cnt_ff, dup_cnt_in;
   logic [COUNTER_W-1:0]   rec_cnt_ff, rec_cnt_in;
   logic [COUNTER_W-1:0]   pkt_cnt_ff, pkt_cnt_in;
   logic [PKT_LEN_W-1:0]   len_ff, len_in;
   logic [SEQ_W-1:0]       seq_ff, seq_in;
   logic [MSG_CNT_W-1:0]   mcnt_ff, mcnt_in;
   verdict_type            verdict_ff, verdict_in;
   logic                   ovf_ff, ovf_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   live_ff, live_in;
   logic [SLOT_W-1:0]      pidx_ff, pidx_in;
   logic                   best_ok_ff, best_ok_in;
   logic [SLOT_W-1:0]      best_idx_ff, best_idx_in;
   logic [SEQ_W-1:0]       best_first_ff, best_first_in;
   logic [GAP_SIZE_W-1:0]  best_size_ff, best_size_in;
   logic [GAP_SIZE_W-1:0]  off_ff, off_in;
   logic                   off_big_ff, off_big_in;
   logic [SEQ_W-1:0]       st_first_ff, st_first_in;
   logic [GAP_SIZE_W-1:0]  st_size_ff, st_size_in;
   logic [SEQ_W-1:0]       st2_first_ff, st2_first_in;
   logic [GAP_SIZE_W-1:0]  st2_size_ff, st2_size_in;
   logic                   st2_pend_ff, st2_pend_in;
   logic                   match_ok_ff, match_ok_in;
   logic [SLOT_W-1:0]      match_idx_ff, match_idx_in;
   logic                   free_ok_ff, free_ok_in;
   logic [SLOT_W-1:0]      free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]       ngaps_ff, ngaps_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   verdict_type            o_verdict_ff, o_verdict_in;
   logic [SEQ_W-1:0]       o_exp_ff, o_exp_in;
   logic [OPEN_GAPS_W-1:0] o_open_ff, o_open_in;
   logic [MISSING_W-1:0]   o_miss_ff, o_miss_in;
   logic [COUNTER_W-1:0]   o_gap_ff, o_gap_in;
   logic [COUNTER_W-1:0]   o_dup_ff, o_dup_in;
   logic [COUNTER_W-1:0]   o_rec_ff, o_rec_in;
   logic [COUNTER_W-1:0]   o_pkt_ff, o_pkt_in;
   logic                   o_ovf_ff, o_ovf_in;

   tbl_cmd_type            tbl_cmd;
   logic [SLOT_W-1:0]      tbl_wr_addr;
   logic [SEQ_W-1:0]       tbl_wr_first;
   logic [GAP_SIZE_W-1:0]  tbl_wr_size;
   logic                   rd_valid;
   logic [SEQ_W-1:0]       rd_first;
   logic [GAP_SIZE_W-1:0]  rd_size;

   logic                   scan_issue;
   logic                   scan_last;
   logic                   take;
   logic                   is_short;
   logic                   seq_eq;
   logic                   seq_gt;
   logic [SEQ_W-1:0]       diff;
   logic [GAP_SIZE_W:0]    end_sum;
   logic                   hit;
   logic [NG_W-1:0]        ngaps_wide;
   logic [MS_W-1:0]        sum_wide;

   sgt_gap_table #(.GAP_SLOTS(GAP_SLOTS)) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .rd_addr  (idx_ff[SLOT_W-1:0]),
      .wr_addr  (tbl_wr_addr),
      .wr_first (tbl_wr_first),
      .wr_size  (tbl_wr_size),
      .rd_valid (rd_valid),
      .rd_first (rd_first),
      .rd_size  (rd_size)
   );

   assign scan_issue = idx_ff < IDX_W'(GAP_SLOTS);
   assign scan_last  = (idx_ff == IDX_W'(GAP_SLOTS)) && live_ff;
   assign take       = req_ch.valid && req_ch.ready;
   assign is_short   = (len_ff == '0) || (len_ff < min_ff);
   assign seq_eq     = (next_exp_ff == '0) || (seq_ff == next_exp_ff);
   assign seq_gt     = seq_ff > next_exp_ff;
   assign diff       = seq_ff - best_first_ff;
   assign end_sum    = {1'b0, off_ff} + {1'b0, mcnt_ff};
   assign hit        = !off_big_ff && (end_sum <= {1'b0, best_size_ff});
   assign ngaps_wide = NG_W'(ngaps_ff);
   assign sum_wide   = MS_W'(sum_ff);

   always_comb begin
      state_in      = state_ff;
      min_in        = csr_wr_en ? csr_wr_data : min_ff;
      next_exp_in   = next_exp_ff;
      gap_cnt_in    = gap_cnt_ff;
      dup_cnt_in    = dup_cnt_ff;
      rec_cnt_in    = rec_cnt_ff;
      pkt_cnt_in    = pkt_cnt_ff;
      len_in        = len_ff;
      seq_in        = seq_ff;
      mcnt_in       = mcnt_ff;
      verdict_in    = verdict_ff;
      ovf_in        = ovf_ff;
      idx_in        = '0;
      live_in       = 1'b0;
      pidx_in       = idx_ff[SLOT_W-1:0];
      best_ok_in    = best_ok_ff;
      best_idx_in   = best_idx_ff;
      best_first_in = best_first_ff;
      best_size_in  = best_size_ff;
      off_in        = off_ff;
      off_big_in    = off_big_ff;
      st_first_in   = st_first_ff;
      st_size_in    = st_size_ff;
      st2_first_in  = st2_first_ff;
      st2_size_in   = st2_size_ff;
      st2_pend_in   = st2_pend_ff;
      match_ok_in   = 1'b0;
      match_idx_in  = match_idx_ff;
      free_ok_in    = 1'b0;
      free_idx_in   = free_idx_ff;
      ngaps_in      = ngaps_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      o_verdict_in  = o_verdict_ff;
      o_exp_in      = o_exp_ff;
      o_open_in     = o_open_ff;
      o_miss_in     = o_miss_ff;
      o_gap_in      = o_gap_ff;
      o_dup_in      = o_dup_ff;
      o_rec_in      = o_rec_ff;
      o_pkt_in      = o_pkt_ff;
      o_ovf_in      = o_ovf_ff;
      tbl_cmd       = '0;
      tbl_wr_addr   = best_idx_ff;
      tbl_wr_first  = st_first_ff;
      tbl_wr_size   = st_size_ff;

      if (state_ff == ST_FIND || state_ff == ST_STORE || state_ff == ST_SUM) begin
         idx_in        = idx_ff;
         live_in       = scan_issue;
         tbl_cmd.rd_en = scan_issue;
         if (scan_issue) begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (state_ff == ST_STORE || state_ff == ST_STORE_WR) begin
         match_ok_in = match_ok_ff;
         free_ok_in  = free_ok_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            ngaps_in = '0;
            sum_in   = '0;
            if (take) begin
               len_in   = req_ch.packet_length;
               seq_in   = req_ch.sequence_req;
               mcnt_in  = req_ch.message_count;
               ovf_in   = 1'b0;
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            best_ok_in = 1'b0;
            if (is_short) begin
               verdict_in = VERDICT_SHORT;
               state_in   = ST_SUM;
            end else begin
               pkt_cnt_in = pkt_cnt_ff + 1'b1;
               if (seq_eq) begin
                  next_exp_in = seq_ff + SEQ_W'(mcnt_ff);
                  verdict_in  = VERDICT_IN_ORDER;
                  state_in    = ST_SUM;
               end else if (seq_gt) begin
                  gap_cnt_in  = gap_cnt_ff + 1'b1;
                  st_first_in = next_exp_ff;
                  st_size_in  = seq_ff[GAP_SIZE_W-1:0] - next_exp_ff[GAP_SIZE_W-1:0];
                  st2_pend_in = 1'b0;
                  next_exp_in = seq_ff + SEQ_W'(mcnt_ff);
                  verdict_in  = VERDICT_GAP;
                  state_in    = ST_STORE;
               end else begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (live_ff && rd_valid && (rd_first <= seq_ff) &&
                (!best_ok_ff || (rd_first > best_first_ff))) begin
               best_ok_in    = 1'b1;
               best_idx_in   = pidx_ff;
               best_first_in = rd_first;
               best_size_in  = rd_size;
            end
            if (scan_last) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            off_in     = diff[GAP_SIZE_W-1:0];
            off_big_in = |diff[SEQ_W-1:GAP_SIZE_W];
            if (best_ok_ff) begin
               state_in = ST_CHECK;
            end else begin
               dup_cnt_in = dup_cnt_ff + 1'b1;
               verdict_in = VERDICT_DUPLICATE;
               state_in   = ST_SUM;
            end
         end
         ST_CHECK: begin
            if (!hit) begin
               dup_cnt_in = dup_cnt_ff + 1'b1;
               verdict_in = VERDICT_DUPLICATE;
               state_in   = ST_SUM;
            end else begin
               rec_cnt_in = rec_cnt_ff + COUNTER_W'(mcnt_ff);
               verdict_in = VERDICT_RECOVERED;
               st2_pend_in = 1'b0;
               if (off_ff == '0 && mcnt_ff == best_size_ff) begin
                  tbl_cmd.clr_valid = 1'b1;
                  state_in          = ST_SUM;
               end else if (off_ff == '0) begin
                  tbl_cmd.clr_valid = 1'b1;
                  st_first_in       = seq_ff + SEQ_W'(mcnt_ff);
                  st_size_in        = best_size_ff - mcnt_ff;
                  state_in          = ST_STORE;
               end else if (end_sum[GAP_SIZE_W-1:0] == best_size_ff) begin
                  tbl_cmd.wr_size = 1'b1;
                  tbl_wr_size     = off_ff;
                  state_in        = ST_SUM;
               end else begin
                  tbl_cmd.clr_valid = 1'b1;
                  st_first_in       = best_first_ff;
                  st_size_in        = off_ff;
                  st2_first_in      = seq_ff + SEQ_W'(mcnt_ff);
                  st2_size_in       = best_size_ff - end_sum[GAP_SIZE_W-1:0];
                  st2_pend_in       = 1'b1;
                  state_in          = ST_STORE;
               end
            end
         end
         ST_STORE: begin
            if (live_ff) begin
               if (rd_valid && (rd_first == st_first_ff) && !match_ok_ff) begin
                  match_ok_in  = 1'b1;
                  match_idx_in = pidx_ff;
               end
               if (!rd_valid && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = pidx_ff;
               end
            end
            if (scan_last) begin
               state_in = ST_STORE_WR;
            end
         end
         ST_STORE_WR: begin
            if (match_ok_ff) begin
               tbl_cmd.wr_size = 1'b1;
               tbl_wr_addr     = match_idx_ff;
            end else if (free_ok_ff) begin
               tbl_cmd.wr_size   = 1'b1;
               tbl_cmd.wr_first  = 1'b1;
               tbl_cmd.set_valid = 1'b1;
               tbl_wr_addr       = free_idx_ff;
            end else begin
               ovf_in = 1'b1;
            end
            match_ok_in = 1'b0;
            free_ok_in  = 1'b0;
            if (st2_pend_ff) begin
               st_first_in = st2_first_ff;
               st_size_in  = st2_size_ff;
               st2_pend_in = 1'b0;
               state_in    = ST_STORE;
            end else begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (live_ff && rd_valid) begin
               ngaps_in = ngaps_ff + 1'b1;
               sum_in   = sum_ff + SUM_W'(rd_size);
            end
            if (scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               o_verdict_in = verdict_ff;
               o_exp_in     = next_exp_ff;
               o_open_in    = (ngaps_wide > NG_W'(31)) ? OPEN_GAPS_W'(31)
                                                       : ngaps_wide[OPEN_GAPS_W-1:0];
               o_miss_in    = (sum_wide > MS_W'(20'hFFFFF)) ? 20'hFFFFF
                                                            : sum_wide[MISSING_W-1:0];
               o_gap_in     = gap_cnt_ff;
               o_dup_in     = dup_cnt_ff;
               o_rec_in     = rec_cnt_ff;
               o_pkt_in     = pkt_cnt_ff;
               o_ovf_in     = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= MIN_HEADER_RESET;
         next_exp_ff  <= '0;
         gap_cnt_ff   <= '0;
         dup_cnt_ff   <= '0;
         rec_cnt_ff   <= '0;
         pkt_cnt_ff   <= '0;
         idx_ff       <= '0;
         live_ff      <= 1'b0;
         match_ok_ff  <= 1'b0;
         free_ok_ff   <= 1'b0;
         best_ok_ff   <= 1'b0;
         st2_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         next_exp_ff  <= next_exp_in;
         gap_cnt_ff   <= gap_cnt_in;
         dup_cnt_ff   <= dup_cnt_in;
         rec_cnt_ff   <= rec_cnt_in;
         pkt_cnt_ff   <= pkt_cnt_in;
         idx_ff       <= idx_in;
         live_ff      <= live_in;
         match_ok_ff  <= match_ok_in;
         free_ok_ff   <= free_ok_in;
         best_ok_ff   <= best_ok_in;
         st2_pend_ff  <= st2_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      seq_ff        <= seq_in;
      mcnt_ff       <= mcnt_in;
      verdict_ff    <= verdict_in;
      ovf_ff        <= ovf_in;
      pidx_ff       <= pidx_in;
      best_idx_ff   <= best_idx_in;
      best_first_ff <= best_first_in;
      best_size_ff  <= best_size_in;
      off_ff        <= off_in;
      off_big_ff    <= off_big_in;
      st_first_ff   <= st_first_in;
      st_size_ff    <= st_size_in;
      st2_first_ff  <= st2_first_in;
      st2_size_ff   <= st2_size_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      ngaps_ff      <= ngaps_in;
      sum_ff        <= sum_in;
      o_verdict_ff  <= o_verdict_in;
      o_exp_ff      <= o_exp_in;
      o_open_ff     <= o_open_in;
      o_miss_ff     <= o_miss_in;
      o_gap_ff      <= o_gap_in;
      o_dup_ff      <= o_dup_in;
      o_rec_ff      <= o_rec_in;
      o_pkt_ff      <= o_pkt_in;
      o_ovf_ff      <= o_ovf_in;
   end

   assign req_ch.ready              = (state_ff == ST_IDLE);
   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.verdict            = o_verdict_ff;
   assign rsp_ch.accepted           = (o_verdict_ff == VERDICT_IN_ORDER) ||
                                      (o_verdict_ff == VERDICT_GAP) ||
                                      (o_verdict_ff == VERDICT_RECOVERED);
   assign rsp_ch.expected_next      = o_exp_ff;
   assign rsp_ch.open_gaps          = o_open_ff;
   assign rsp_ch.missing_total      = o_miss_ff;
   assign rsp_ch.gap_openings       = o_gap_ff;
   assign rsp_ch.duplicates         = o_dup_ff;
   assign rsp_ch.recovered_messages = o_rec_ff;
   assign rsp_ch.packets_seen       = o_pkt_ff;
   assign rsp_ch.table_overflow     = o_ovf_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_ovf_ff |->
         (o_verdict_ff == VERDICT_GAP) || (o_verdict_ff == VERDICT_RECOVERED))
      else $error("table overflow reported without a gap store");

   assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(GAP_SLOTS))
      else $error("table scan index ran past the last slot");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_JUDGE) && !is_short |=> pkt_cnt_ff == $past(pkt_cnt_ff) + 1'b1)
      else $error("full header not counted");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready) |=>
         rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished result not loaded into the output register");

endmodule
